// ===== design/uvfo_pkg.sv =====
`default_nettype none

package uvfo_pkg;

  // Default coordinate width
  localparam int unsigned COORD_BITS_DEF = 16;

  // Result stream payload width (overlap bit padded to a byte)
  localparam int unsigned OUT_W = 8;

  // Operation codes carried in tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // Vertex code: face select in the top bit, vertex index below
  localparam logic FACE_TEST = 1'b0;
  localparam logic FACE_REF  = 1'b1;

  // Tag that travels with one cross-product evaluation
  typedef struct packed {
    logic       edge_grp;  // group belongs to an edge-pair test
    logic       last;      // final evaluation of its group
    logic       gate;      // group is real for the current face shapes
    logic [1:0] sub;       // position within its group
  } uvfo_tag_t;

  // Controller to datapath
  typedef struct packed {
    logic       cap_test;  // capture incoming face, clear hit flag
    logic       cap_ref;   // store incoming face as reference
    logic       issue;     // start one cross-product evaluation
    logic       out_load;  // move hit flag into result register
    logic [2:0] opa;       // vertex code of A
    logic [2:0] opb;       // vertex code of B
    logic [2:0] opo;       // vertex code of origin O
    uvfo_tag_t  tag;
  } uvfo_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;       // evaluations still in the pipeline
    logic test_quad;  // captured face is a quad
    logic ref_quad;   // reference face is a quad
  } uvfo_status_t;

endpackage

`default_nettype wire

// ===== design/uvfo_dp.sv =====
`default_nettype none

module uvfo_dp #(
  parameter int unsigned COORD_BITS = uvfo_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [6*COORD_BITS:0]   face_i,    // u0,v0,u1,v1,u2,v2,is_quad
  input  wire uvfo_pkg::uvfo_cmd_t     cmd_i,
  output uvfo_pkg::uvfo_status_t       status_o,
  output logic                         overlap_o
);

  import uvfo_pkg::*;

  localparam int unsigned VW = COORD_BITS + 2;  // vertex incl. derived fourth
  localparam int unsigned DW = COORD_BITS + 3;  // vertex difference
  localparam int unsigned PW = 2 * DW;          // product
  localparam int unsigned SW = PW + 1;          // difference of products

  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  logic signed [VW-1:0] in_x [4];
  logic signed [VW-1:0] in_y [4];
  logic                 in_quad;

  logic signed [VW-1:0] test_x_q [4];
  logic signed [VW-1:0] test_y_q [4];
  logic                 test_quad_q;
  logic signed [VW-1:0] ref_x_q [4];
  logic signed [VW-1:0] ref_y_q [4];
  logic                 ref_quad_q;

  logic signed [VW-1:0] vx [8];
  logic signed [VW-1:0] vy [8];

  logic signed [DW-1:0] dax_d, day_d, dbx_d, dby_d;
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q;
  logic                 vd_q;
  uvfo_tag_t            td_q;

  logic signed [PW-1:0] p_d, q_d;
  logic signed [PW-1:0] p_q, q_q;
  logic                 vm_q;
  uvfo_tag_t            tm_q;

  logic signed [SW-1:0] diff;
  sgn_t                 fresh;
  sgn_t                 sig_q [3];
  logic                 any_neg, any_pos, contained, crossing, grp_hit;
  logic                 hit_q;
  logic                 overlap_q;

  // Unpack incoming face, sign extend, derive fourth vertex
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_x[k] = {{2{face_i[(2*k+1)*COORD_BITS-1]}}, face_i[2*k*COORD_BITS +: COORD_BITS]};
      in_y[k] = {{2{face_i[(2*k+2)*COORD_BITS-1]}},
                 face_i[(2*k+1)*COORD_BITS +: COORD_BITS]};
    end
    in_x[3] = in_x[2] + in_x[1] - in_x[0];
    in_y[3] = in_y[2] + in_y[1] - in_y[0];
    in_quad = face_i[6*COORD_BITS];
  end

  // Hold the face under test
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_test) begin
      for (int k = 0; k < 4; k++) begin
        test_x_q[k] <= in_x[k];
        test_y_q[k] <= in_y[k];
      end
      test_quad_q <= in_quad;
    end
  end

  // Hold the reference face, zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        ref_x_q[k] <= '0;
        ref_y_q[k] <= '0;
      end
      ref_quad_q <= 1'b0;
    end else if (cmd_i.cap_ref) begin
      for (int k = 0; k < 4; k++) begin
        ref_x_q[k] <= in_x[k];
        ref_y_q[k] <= in_y[k];
      end
      ref_quad_q <= in_quad;
    end
  end

  // Vertex table addressed by vertex code
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vx[k]     = test_x_q[k];
      vy[k]     = test_y_q[k];
      vx[k + 4] = ref_x_q[k];
      vy[k + 4] = ref_y_q[k];
    end
  end

  // Select operands and form differences A-O and B-O
  always_comb begin
    dax_d = DW'(vx[cmd_i.opa]) - DW'(vx[cmd_i.opo]);
    day_d = DW'(vy[cmd_i.opa]) - DW'(vy[cmd_i.opo]);
    dbx_d = DW'(vx[cmd_i.opb]) - DW'(vx[cmd_i.opo]);
    dby_d = DW'(vy[cmd_i.opb]) - DW'(vy[cmd_i.opo]);
  end

  always_ff @(posedge clk_i) begin
    dax_q <= dax_d;
    day_q <= day_d;
    dbx_q <= dbx_d;
    dby_q <= dby_d;
    td_q  <= cmd_i.tag;
  end

  // Form both products of the cross product
  always_comb begin
    p_d = dax_q * dby_q;
    q_d = dbx_q * day_q;
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    q_q  <= q_d;
    tm_q <= td_q;
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      vm_q <= 1'b0;
    end else begin
      vd_q <= cmd_i.issue;
      vm_q <= vd_q;
    end
  end

  // Sign of the cross product and group evaluation
  always_comb begin
    diff       = SW'(p_q) - SW'(q_q);
    fresh.neg  = diff[SW-1];
    fresh.zero = (diff == '0);
    any_neg    = sig_q[0].neg | sig_q[1].neg | fresh.neg;
    any_pos    = (!sig_q[0].neg && !sig_q[0].zero) || (!sig_q[1].neg && !sig_q[1].zero) ||
                 (!fresh.neg && !fresh.zero);
    contained  = !(any_neg && any_pos);
    crossing   = (sig_q[0] != sig_q[1]) && (sig_q[2] != fresh);
    grp_hit    = tm_q.edge_grp ? crossing : contained;
  end

  // Keep earlier signs of the current group
  always_ff @(posedge clk_i) begin
    if (vm_q && !tm_q.last) begin
      sig_q[tm_q.sub] <= fresh;
    end
  end

  // Accumulate the overlap flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.cap_test) begin
      hit_q <= 1'b0;
    end else if (vm_q && tm_q.last && tm_q.gate && grp_hit) begin
      hit_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      overlap_q <= hit_q;
    end
  end

  assign status_o.busy      = vd_q | vm_q;
  assign status_o.test_quad = test_quad_q;
  assign status_o.ref_quad  = ref_quad_q;
  assign overlap_o          = overlap_q;

endmodule

`default_nettype wire

// ===== design/uvfo_ctrl.sv =====
`default_nettype none

module uvfo_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  input  wire logic              s_op_i,
  output logic                   s_ready_o,
  input  wire logic              m_ready_i,
  output logic                   m_valid_o,
  input  wire uvfo_pkg::uvfo_status_t status_i,
  output uvfo_pkg::uvfo_cmd_t    cmd_o
);

  import uvfo_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       phase_q, phase_d;  // 0 containment, 1 edge pairs
  logic [1:0] i_q, i_d;          // vertex of face under test
  logic [1:0] g_q, g_d;          // reference triangle or reference edge
  logic [1:0] s_q, s_d;          // evaluation within group
  logic       out_valid_q, out_valid_d;

  logic       accept, last_s, last_g, last_i, step_last, ivalid, can_out;
  logic       cap_test, cap_ref, issue, out_load;
  logic [2:0] p1, q1, p2, q2, ta, tb, tc;

  function automatic logic [2:0] vcode(logic face, logic [1:0] idx);
    vcode = {face, idx};
  endfunction

  // Successor vertex around a triangle or a quad
  function automatic logic [1:0] nxt(logic [1:0] idx, logic quad);
    if (quad) begin
      nxt = idx + 2'd1;
    end else if (idx == 2'd2) begin
      nxt = 2'd0;
    end else begin
      nxt = idx + 2'd1;
    end
  endfunction

  always_comb begin
    accept    = (state_q == ST_IDLE) && s_valid_i;
    last_s    = phase_q ? (s_q == 2'd3) : (s_q == 2'd2);
    last_g    = phase_q ? (g_q == 2'd3) : (g_q == 2'd1);
    last_i    = (i_q == 2'd3);
    step_last = phase_q && last_i && last_g && last_s;
    ivalid    = (i_q != 2'd3) || status_i.test_quad;
    can_out   = !status_i.busy && (!out_valid_q || m_ready_i);
  end

  // Operand codes for the current evaluation
  always_comb begin
    p1 = vcode(FACE_TEST, i_q);
    q1 = vcode(FACE_TEST, nxt(i_q, status_i.test_quad));
    p2 = vcode(FACE_REF, g_q);
    q2 = vcode(FACE_REF, nxt(g_q, status_i.ref_quad));
    ta = g_q[0] ? vcode(FACE_REF, 2'd3) : vcode(FACE_REF, 2'd0);
    tb = vcode(FACE_REF, 2'd1);
    tc = vcode(FACE_REF, 2'd2);

    cmd_o.cap_test = cap_test;
    cmd_o.cap_ref  = cap_ref;
    cmd_o.issue    = issue;
    cmd_o.out_load = out_load;

    cmd_o.opa = p1;
    cmd_o.opb = ta;
    cmd_o.opo = tb;
    if (phase_q) begin
      case (s_q)
        2'd0: begin
          cmd_o.opa = q1; cmd_o.opb = p2; cmd_o.opo = p1;
        end
        2'd1: begin
          cmd_o.opa = q1; cmd_o.opb = q2; cmd_o.opo = p1;
        end
        2'd2: begin
          cmd_o.opa = q2; cmd_o.opb = p1; cmd_o.opo = p2;
        end
        default: begin
          cmd_o.opa = q2; cmd_o.opb = q1; cmd_o.opo = p2;
        end
      endcase
    end else begin
      case (s_q)
        2'd1: begin
          cmd_o.opa = p1; cmd_o.opb = tb; cmd_o.opo = tc;
        end
        2'd2: begin
          cmd_o.opa = p1; cmd_o.opb = tc; cmd_o.opo = ta;
        end
        default: begin
          cmd_o.opa = p1; cmd_o.opb = ta; cmd_o.opo = tb;
        end
      endcase
    end

    cmd_o.tag.edge_grp = phase_q;
    cmd_o.tag.last     = last_s;
    cmd_o.tag.sub      = s_q;
    cmd_o.tag.gate     = phase_q ? (ivalid && ((g_q != 2'd3) || status_i.ref_quad))
                                 : (ivalid && (!g_q[0] || status_i.ref_quad));
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    i_d      = i_q;
    g_d      = g_q;
    s_d      = s_q;
    cap_test = 1'b0;
    cap_ref  = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_op_i == OP_TEST) begin
            cap_test = 1'b1;
            phase_d  = 1'b0;
            i_d      = 2'd0;
            g_d      = 2'd0;
            s_d      = 2'd0;
            state_d  = ST_RUN;
          end else begin
            cap_ref = 1'b1;
          end
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (step_last) begin
          state_d = ST_DRAIN;
        end
        // advance group counters
        if (last_s) begin
          s_d = 2'd0;
          if (last_g) begin
            g_d = 2'd0;
            if (last_i) begin
              i_d     = 2'd0;
              phase_d = 1'b1;
            end else begin
              i_d = i_q + 2'd1;
            end
          end else begin
            g_d = g_q + 2'd1;
          end
        end else begin
          s_d = s_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (can_out) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q && !m_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      i_q         <= 2'd0;
      g_q         <= 2'd0;
      s_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      i_q         <= i_d;
      g_q         <= g_d;
      s_q         <= s_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/uv_face_overlap_test_top.sv =====
`default_nettype none

// Channel  Dir  Width (default)  Contents
// s_axis   in   tdata 104        u0,v0,u1,v1,u2,v2,is_quad; tuser 1: op
// m_axis   out  tdata 8          overlap
//
// A load item is stored as it is taken. A test item holds the input closed from its
// transfer until its result is loaded: 88 cross-product evaluations, one per cycle,
// through a single difference / multiply / sign pipeline, then drain and result
// load. Reset clears the reference face to zeros.
// The result waits in an output register; input is taken again once the
// result is registered, and a further test result holds until it is taken.

module uv_face_overlap_test_top #(
  parameter int unsigned COORD_BITS = uvfo_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_W = ((6 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [IN_W-1:0]            s_axis_tdata,  // u0,v0,u1,v1,u2,v2,is_quad,pad
  input  wire logic                       s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [uvfo_pkg::OUT_W-1:0]      m_axis_tdata   // overlap,pad
);

  import uvfo_pkg::*;

  uvfo_cmd_t    cmd;
  uvfo_status_t st;
  logic         overlap;

  uvfo_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .status_i  (st),
    .cmd_o     (cmd)
  );

  uvfo_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .face_i    (s_axis_tdata[6*COORD_BITS:0]),
    .cmd_i     (cmd),
    .status_o  (st),
    .overlap_o (overlap)
  );

  assign m_axis_tdata = {{(OUT_W-1){1'b0}}, overlap};

  // Input is never taken while evaluations are in flight
  a_idle_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !st.busy) else $error("input ready while pipeline busy");

  // Issue only while input is closed
  a_issue_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !s_axis_tready) else $error("issue while input open");

  // Never overwrite a result not yet transferred
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // A loaded result is presented in the next cycle
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid) else $error("loaded result not presented");

endmodule

`default_nettype wire
